/* rtl/svpd_pkg.sv */
// svpd_pkg: shared constants, types and the sine table builder for the
// space vector pwm duty block. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svpd_pkg;

    localparam int ANGLE_WIDTH      = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int COMPARE_WIDTH    = 16;

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int T_W    = 30;
    localparam int D_W    = 31;
    localparam int PER_W  = (COMPARE_WIDTH < 16) ? COMPARE_WIDTH : 16;

    localparam int DIV_BITS  = T_W;
    localparam int DIV_STEPS = 2;
    localparam int DIV_NS    = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] PI3_Q30  = 64'd1124419809;
    localparam logic [15:0] AMP_FULL = 16'd32768;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_ENABLE = 1'b1;

    typedef logic [D_W-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    typedef struct packed {
        logic [2:0]     sector;
        logic [T_W-1:0] t1;
        logic [T_W-1:0] t2;
        logic [D_W-1:0] sum;
        logic           renorm;
    } t_front_word;

    typedef struct packed {
        logic [2:0]     sector;
        logic [T_W-1:0] t1;
        logic [T_W-1:0] t2;
        logic [T_W-1:0] quo;
        logic           renorm;
    } t_div_word;

    function automatic t_sine_rom f_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x  = (64'(i) * PI3_Q30) / 64'(SINE_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            rom[i] = D_W'((x * t) >> 30);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

/* rtl/svpd_front.sv */
// svpd_front: sector split, sine table lookup, active time products.
// depends on svpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpd_front import svpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [15:0] i_angle,
    input  wire logic [15:0] i_amplitude,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      t_front_word o_word
);

    localparam t_sine_rom SINE_ROM = f_sine_rom();

    logic [3:0]  r_v;
    logic [4:0]  w_rdy;

    logic [ANGLE_WIDTH-1:0]       w_ang;
    logic [ANGLE_WIDTH+2:0]       w_scaled;
    logic [ANGLE_WIDTH+IDX_W-1:0] w_prod;
    logic [2:0]                   n_sector;
    logic [IDX_W-1:0]             n_idx;
    logic [15:0]                  n_a;

    logic [2:0]       r_sector0, r_sector1, r_sector2;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_a0, r_a1;
    logic [D_W-1:0]   r_s1, r_s2;
    logic [T_W-1:0]   r_t1, r_t2;
    logic [46:0]      w_p1, w_p2;
    t_front_word      r_word;

    always_comb begin
        w_rdy[4] = i_ready;
        for (int k = 3; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[3];
    assign o_word  = r_word;

    assign w_ang    = ANGLE_WIDTH'(i_angle);
    assign w_scaled = {3'b000, w_ang} * (ANGLE_WIDTH + 3)'(6);
    assign n_sector = 3'(w_scaled >> ANGLE_WIDTH);
    assign w_prod   = (ANGLE_WIDTH + IDX_W)'(w_scaled[ANGLE_WIDTH-1:0])
                    * (ANGLE_WIDTH + IDX_W)'(SINE_TABLE_DEPTH);
    assign n_idx    = IDX_W'(w_prod >> ANGLE_WIDTH);
    assign n_a      = (i_amplitude > AMP_FULL) ? AMP_FULL : i_amplitude;

    assign w_p1 = 47'(r_a1) * 47'(r_s1);
    assign w_p2 = 47'(r_a1) * 47'(r_s2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_sector0 <= n_sector;
            r_idx     <= n_idx;
            r_a0      <= n_a;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_s1      <= SINE_ROM[IDX_W'(SINE_TABLE_DEPTH) - r_idx];
            r_s2      <= SINE_ROM[r_idx];
            r_sector1 <= r_sector0;
            r_a1      <= r_a0;
        end
        if (w_rdy[2] && r_v[1]) begin
            r_t1      <= T_W'(w_p1 >> 15);
            r_t2      <= T_W'(w_p2 >> 15);
            r_sector2 <= r_sector1;
        end
        if (w_rdy[3] && r_v[2]) begin
            r_word.sector <= r_sector2;
            r_word.t1     <= r_t1;
            r_word.t2     <= r_t2;
            r_word.sum    <= {1'b0, r_t1} + {1'b0, r_t2};
            r_word.renorm <= ({1'b0, r_t1} + {1'b0, r_t2}) > D_W'(Q30_ONE);
        end
    end

`ifndef SYNTHESIS
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> r_sector0 <= 3'd5)
        else $error("sector out of range");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v[0] && r_v[3] && !i_ready))
        else $error("front stalled without full pipe");
`endif

endmodule

`default_nettype wire

/* rtl/svpd_div.sv */
// svpd_div: pipelined restoring divider for active time renormalization.
// depends on svpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpd_div import svpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire t_front_word i_word,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      t_div_word   o_word
);

    logic [DIV_NS-1:0] r_v;
    logic [DIV_NS:0]   w_rdy;
    logic [D_W-1:0]    r_rem [DIV_NS];
    logic [T_W-1:0]    r_quo [DIV_NS];
    logic [D_W-1:0]    r_dvs [DIV_NS];
    t_div_word         r_w   [DIV_NS];
    logic [D_W-1:0]    n_rem [DIV_NS];
    logic [T_W-1:0]    n_quo [DIV_NS];

    always_comb begin
        w_rdy[DIV_NS] = i_ready;
        for (int k = DIV_NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign o_ready = w_rdy[0];
    assign o_valid = r_v[DIV_NS-1];

    always_comb begin
        logic [D_W-1:0] rem;
        logic [T_W-1:0] quo;
        logic [D_W-1:0] dvs;
        logic [D_W:0]   rem2;
        for (int k = 0; k < DIV_NS; k++) begin
            if (k == 0) begin
                rem = {1'b0, i_word.t1};
                quo = '0;
                dvs = i_word.sum;
            end else begin
                rem = r_rem[k-1];
                quo = r_quo[k-1];
                dvs = r_dvs[k-1];
            end
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (k * DIV_STEPS + j < DIV_BITS) begin
                    rem2 = {rem, 1'b0};
                    if (rem2 >= {1'b0, dvs}) begin
                        rem = D_W'(rem2 - {1'b0, dvs});
                        quo = {quo[T_W-2:0], 1'b1};
                    end else begin
                        rem = D_W'(rem2);
                        quo = {quo[T_W-2:0], 1'b0};
                    end
                end
            end
            n_rem[k] = rem;
            n_quo[k] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < DIV_NS; k++) begin
                if (w_rdy[k]) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_NS; k++) begin
            if (k == 0) begin
                if (w_rdy[0] && i_valid) begin
                    r_rem[0]       <= n_rem[0];
                    r_quo[0]       <= n_quo[0];
                    r_dvs[0]       <= i_word.sum;
                    r_w[0].sector  <= i_word.sector;
                    r_w[0].t1      <= i_word.t1;
                    r_w[0].t2      <= i_word.t2;
                    r_w[0].quo     <= '0;
                    r_w[0].renorm  <= i_word.renorm;
                end
            end else if (w_rdy[k] && r_v[k-1]) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_dvs[k] <= r_dvs[k-1];
                r_w[k]   <= r_w[k-1];
            end
        end
    end

    always_comb begin
        o_word     = r_w[DIV_NS-1];
        o_word.quo = r_quo[DIV_NS-1];
    end

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_word)))
        else $error("divider output changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/svpd_back.sv */
// svpd_back: zero vector split, sector mapping and compare scaling.
// depends on svpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svpd_back import svpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire t_div_word   i_word,
    input  wire logic [15:0] i_period,
    input  wire logic        i_enable,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [15:0] o_cmp_a,
    output      logic [15:0] o_cmp_b,
    output      logic [15:0] o_cmp_c,
    output      logic [2:0]  o_sector_index,
    output      logic        o_status
);

    logic [1:0] r_v;
    logic [2:0] w_rdy;

    logic [D_W-1:0] w_x1, w_x2, w_t0, w_h;
    logic [D_W-1:0] n_ta, n_tb, n_tc;
    logic [D_W-1:0] r_ta, r_tb, r_tc;
    logic [2:0]     r_sector;
    logic [PER_W-1:0]     w_per;
    logic [D_W+PER_W-1:0] w_pa, w_pb, w_pc;

    logic [15:0] r_ca, r_cb, r_cc;
    logic [2:0]  r_sec_out;
    logic        r_status;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[1];

    always_comb begin
        if (i_word.renorm) begin
            w_x1 = {1'b0, i_word.quo};
            w_x2 = D_W'(Q30_ONE) - {1'b0, i_word.quo};
            w_t0 = '0;
        end else begin
            w_x1 = {1'b0, i_word.t1};
            w_x2 = {1'b0, i_word.t2};
            w_t0 = D_W'(Q30_ONE) - {1'b0, i_word.t1} - {1'b0, i_word.t2};
        end
        w_h = w_t0 >> 1;
        case (i_word.sector)
            3'd0: begin
                n_ta = w_x1 + w_x2 + w_h; n_tb = w_x2 + w_h;        n_tc = w_h;
            end
            3'd1: begin
                n_ta = w_x1 + w_h;        n_tb = w_x1 + w_x2 + w_h; n_tc = w_h;
            end
            3'd2: begin
                n_ta = w_h;               n_tb = w_x1 + w_x2 + w_h; n_tc = w_x2 + w_h;
            end
            3'd3: begin
                n_ta = w_h;               n_tb = w_x1 + w_h;        n_tc = w_x1 + w_x2 + w_h;
            end
            3'd4: begin
                n_ta = w_x2 + w_h;        n_tb = w_h;               n_tc = w_x1 + w_x2 + w_h;
            end
            default: begin
                n_ta = w_x1 + w_x2 + w_h; n_tb = w_h;               n_tc = w_x1 + w_h;
            end
        endcase
    end

    assign w_per = PER_W'(i_period);
    assign w_pa  = (D_W + PER_W)'(r_ta) * (D_W + PER_W)'(w_per);
    assign w_pb  = (D_W + PER_W)'(r_tb) * (D_W + PER_W)'(w_per);
    assign w_pc  = (D_W + PER_W)'(r_tc) * (D_W + PER_W)'(w_per);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_ta     <= n_ta;
            r_tb     <= n_tb;
            r_tc     <= n_tc;
            r_sector <= i_word.sector;
        end
        if (w_rdy[1] && r_v[0]) begin
            if (i_enable) begin
                r_ca      <= 16'(PER_W'(w_pa >> 30));
                r_cb      <= 16'(PER_W'(w_pb >> 30));
                r_cc      <= 16'(PER_W'(w_pc >> 30));
                r_sec_out <= r_sector;
                r_status  <= 1'b0;
            end else begin
                r_ca      <= '0;
                r_cb      <= '0;
                r_cc      <= '0;
                r_sec_out <= '0;
                r_status  <= 1'b1;
            end
        end
    end

    assign o_cmp_a        = r_ca;
    assign o_cmp_b        = r_cb;
    assign o_cmp_c        = r_cc;
    assign o_sector_index = r_sec_out;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
            (r_ca == 16'd0 && r_cb == 16'd0 && r_cc == 16'd0 && r_sec_out == 3'd0))
        else $error("disabled word carries nonzero fields");
`endif

endmodule

`default_nettype wire

/* rtl/space_vector_pwm_duty.sv */
// space_vector_pwm_duty: top level, configuration registers and stream ports.
// depends on svpd_pkg, svpd_front, svpd_div, svpd_back.
//
// usage:
//   s channel takes one word per cycle: angle (fraction of a turn) and
//   amplitude (32768 = full scale). m channel returns one word per input:
//   three phase compare counts, with sector and status in tuser.
//   cfg channel writes index 0 = period, index 1 = enable; it is always
//   ready and should only be written while no word is in flight.
//   from input accept to output valid a word passes 4 front stages
//   (sector split, sine table read, products, sum), 15 divider stages of
//   two quotient bits each, 2 back stages (mapping, compare multiply).
//   throughput is one word per cycle; each stage has its own valid bit and
//   moves when the stage after it is empty or moving, so bubbles close up.
//   when the m side stalls, words pile up stage by stage and s_tready drops
//   only when every stage holds a word; nothing is lost or repeated.
//   reset empties the pipeline, period returns to 8499 and enable to 0;
//   while enable is 0 every word comes back with status 1 and zero compares.
`timescale 1ns / 1ps
`default_nettype none

module space_vector_pwm_duty import svpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // angle, amplitude
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata,   // cmp_a, cmp_b, cmp_c
    output      logic [3:0]  m_tuser,   // sector_index, status
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_period;
    logic        r_enable;

    logic        w_f_valid, w_f_ready;
    t_front_word w_f_word;
    logic        w_d_valid, w_d_ready;
    t_div_word   w_d_word;
    logic [15:0] w_ca, w_cb, w_cc;
    logic [2:0]  w_sector;
    logic        w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd8499;
            r_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default:    r_period <= r_period;
            endcase
        end
    end

    svpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_angle     (s_tdata[15:0]),
        .i_amplitude (s_tdata[31:16]),
        .o_valid     (w_f_valid),
        .i_ready     (w_f_ready),
        .o_word      (w_f_word)
    );

    svpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_word  (w_f_word),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_word  (w_d_word)
    );

    svpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_d_valid),
        .o_ready        (w_d_ready),
        .i_word         (w_d_word),
        .i_period       (r_period),
        .i_enable       (r_enable),
        .o_valid        (m_tvalid),
        .i_ready        (m_tready),
        .o_cmp_a        (w_ca),
        .o_cmp_b        (w_cb),
        .o_cmp_c        (w_cc),
        .o_sector_index (w_sector),
        .o_status       (w_status)
    );

    assign m_tdata = {w_cc, w_cb, w_ca};
    assign m_tuser = {w_status, w_sector};

endmodule

`default_nettype wire

/* tb/sv/tb_space_vector_pwm_duty.sv */
// tb_space_vector_pwm_duty: self-checking bench for the space vector pwm duty block.
// a fixed-point duty predictor feeds a queue of expected words, and random idling
// on both stream sides stresses the handshake. depends on svpd_pkg and the rtl.
`timescale 1ns / 1ps

class svpd_duty_board;
    typedef struct packed {
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
        logic [2:0]  sector;
        logic        status;
    } t_duty_word;

    t_duty_word  pending[$];
    logic [15:0] period;
    logic        enable;
    int          errors;

    function new();
        period = 16'd8499;
        enable = 1'b0;
        errors = 0;
    endfunction

    function logic [63:0] sine_steps(logic [63:0] steps);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (steps * 64'd1124419809) / 64'(svpd_pkg::SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = (64'd1 << 30) - x2 / 64'd72;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
        t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    function logic [15:0] scale_duty(logic [63:0] duty);
        logic [63:0] c;
        if (duty > (64'd1 << 30)) duty = 64'd1 << 30;
        c = (duty * 64'(period)) >> 30;
        if (c > 64'(period)) c = 64'(period);
        return c[15:0];
    endfunction

    function void note_input(logic [15:0] angle, logic [15:0] amp);
        t_duty_word  w;
        logic [63:0] scaled, sec, rem, idx, a, t1, t2, t0, h, ta, tb, tc;
        logic [63:0] one;
        one = 64'd1 << 30;
        w = '0;
        if (!enable) begin
            w.status = 1'b1;
            pending.push_back(w);
            return;
        end
        scaled = 64'(angle) * 64'd6;
        sec = scaled >> 16;
        if (sec > 5) sec = 5;
        rem = scaled - (sec << 16);
        idx = (rem * 64'(svpd_pkg::SINE_TABLE_DEPTH)) >> 16;
        if (idx > 64'(svpd_pkg::SINE_TABLE_DEPTH)) idx = 64'(svpd_pkg::SINE_TABLE_DEPTH);
        a = (amp > 16'd32768) ? 64'd32768 : 64'(amp);
        t1 = (a * sine_steps(64'(svpd_pkg::SINE_TABLE_DEPTH) - idx)) >> 15;
        t2 = (a * sine_steps(idx)) >> 15;
        if (t1 + t2 > one) begin
            t1 = (t1 * one) / (t1 + t2);
            t2 = one - t1;
            t0 = 0;
        end else begin
            t0 = one - t1 - t2;
        end
        h = t0 >> 1;
        case (sec)
            0: begin ta = t1 + t2 + h; tb = t2 + h; tc = h; end
            1: begin ta = t1 + h; tb = t1 + t2 + h; tc = h; end
            2: begin ta = h; tb = t1 + t2 + h; tc = t2 + h; end
            3: begin ta = h; tb = t1 + h; tc = t1 + t2 + h; end
            4: begin ta = t2 + h; tb = h; tc = t1 + t2 + h; end
            default: begin ta = t1 + t2 + h; tb = h; tc = t1 + h; end
        endcase
        w.ca = scale_duty(ta);
        w.cb = scale_duty(tb);
        w.cc = scale_duty(tc);
        w.sector = sec[2:0];
        pending.push_back(w);
    endfunction

    function void check_result(logic [47:0] data, logic [3:0] user);
        t_duty_word w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word tdata=%h tuser=%h", $time, data, user);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (data[15:0] !== w.ca) begin
            $display("%0t: cmp_a expected %0d got %0d", $time, w.ca, data[15:0]);
            errors++;
        end
        if (data[31:16] !== w.cb) begin
            $display("%0t: cmp_b expected %0d got %0d", $time, w.cb, data[31:16]);
            errors++;
        end
        if (data[47:32] !== w.cc) begin
            $display("%0t: cmp_c expected %0d got %0d", $time, w.cc, data[47:32]);
            errors++;
        end
        if (user[2:0] !== w.sector) begin
            $display("%0t: sector expected %0d got %0d", $time, w.sector, user[2:0]);
            errors++;
        end
        if (user[3] !== w.status) begin
            $display("%0t: status expected %0d got %0d", $time, w.status, user[3]);
            errors++;
        end
    endfunction
endclass

module tb_space_vector_pwm_duty;
    import svpd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // angle, amplitude
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // cmp_a, cmp_b, cmp_c
    logic [3:0]  m_tuser;           // sector_index, status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    svpd_duty_board board = new();
    bit             sending_done = 1'b0;

    space_vector_pwm_duty DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PERIOD) board.period = val;
        else board.enable = val[0];
        @(posedge i_clk);
    endtask

    task automatic send_word(logic [15:0] angle, logic [15:0] amp, bit calm);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {amp, angle};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_input(angle, amp);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'(($urandom_range(0, 6) * 65536) / 6 + $urandom_range(0, 2) - 1);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_amp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'($urandom_range(32768, 65535));
        if (r < 3) return 16'($urandom_range(32760, 32770));
        return 16'($urandom_range(0, 32768));
    endfunction

    // receiver with random stalls, long stretches without any
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end

    initial begin
        logic [15:0] periods[5];
        periods = '{16'd8499, 16'd0, 16'd65535, 16'd1, 16'd1000};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled block, reset period
        send_word(16'h0000, 16'h8000, 1'b1);
        send_word(16'hFFFF, 16'hFFFF, 1'b1);
        send_word(16'h5555, 16'h1234, 1'b1);
        drain();
        write_reg(CFG_ENABLE, 16'd1);

        // directed: sector edges, amplitude extremes
        send_word(16'h0000, 16'h0000, 1'b0);
        send_word(16'h0000, 16'h8000, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(16'h2AAA, 16'h8000, 1'b0);
        send_word(16'h2AAB, 16'h8000, 1'b0);
        send_word(16'h5555, 16'h8001, 1'b0);
        send_word(16'h5556, 16'h7FFF, 1'b0);
        send_word(16'h8000, 16'h8000, 1'b0);
        send_word(16'hAAAA, 16'h4000, 1'b0);
        send_word(16'hAAAB, 16'hFFFF, 1'b0);
        send_word(16'hD555, 16'h8000, 1'b0);
        send_word(16'hD556, 16'h0001, 1'b0);
        send_word(16'h1555, 16'h8000, 1'b0);
        send_word(16'h9555, 16'h8000, 1'b0);
        send_word(16'hF000, 16'h8000, 1'b0);
        drain();

        foreach (periods[p]) begin
            write_reg(CFG_PERIOD, periods[p]);
            write_reg(CFG_ENABLE, 16'(p != 3));
            repeat (p == 2 ? 350 : 250) send_word(rand_angle(), rand_amp(), 1'b0);
            drain();
        end
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_PERIOD, 16'($urandom));
        repeat (250) send_word(rand_angle(), rand_amp(), $urandom_range(0, 1) == 0);
        drain();
        sending_done = 1'b1;
    end

    initial begin
        wait (sending_done);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("space_vector_pwm_duty test passed");
        end else begin
            $display("space_vector_pwm_duty test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("space_vector_pwm_duty test failed");
        $finish;
    end
endmodule
